// ----- rtl/core/md2_pkg.sv -----
`timescale 1ns / 1ps

package md2_pkg;

   localparam int ROUNDS      = 18;
   localparam int MIX_BYTES   = 48;
   localparam int BLOCK_BYTES = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_MIX,
      ST_CSUM,
      ST_COPY,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_PAD,
      PH_SUM
   } phase_type;

   typedef struct packed {
      logic       buf_shift;
      logic       buf_use_pad;
      logic [7:0] pad_byte;
      logic       load_mix;
      logic       mix_step;
      logic       round_end;
      logic [4:0] round;
      logic       csum_step;
      logic       copy_csum;
      logic       emit_shift;
      logic       clear;
   } cmd_type;

   localparam logic [7:0] PI_ROM [256] = '{
      8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1, 8'd61, 8'd54, 8'd84,
      8'd161, 8'd236, 8'd240, 8'd6, 8'd19, 8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199,
      8'd115, 8'd140, 8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202,
      8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212, 8'd224, 8'd22, 8'd103, 8'd66, 8'd111,
      8'd24, 8'd138, 8'd23, 8'd229, 8'd18, 8'd190, 8'd78, 8'd196, 8'd214, 8'd218,
      8'd158, 8'd222, 8'd73, 8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238,
      8'd122, 8'd169, 8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63, 8'd148,
      8'd194, 8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33, 8'd128, 8'd127, 8'd93, 8'd154,
      8'd90, 8'd144, 8'd50, 8'd39, 8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247, 8'd151,
      8'd3, 8'd255, 8'd25, 8'd48, 8'd179, 8'd72, 8'd165, 8'd181, 8'd209, 8'd215, 8'd94,
      8'd146, 8'd42, 8'd172, 8'd86, 8'd170, 8'd198, 8'd79, 8'd184, 8'd56, 8'd210,
      8'd150, 8'd164, 8'd125, 8'd182, 8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116,
      8'd4, 8'd241, 8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32,
      8'd134, 8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2, 8'd27, 8'd96, 8'd37,
      8'd173, 8'd174, 8'd176, 8'd185, 8'd246, 8'd28, 8'd70, 8'd97, 8'd105, 8'd52,
      8'd64, 8'd126, 8'd15, 8'd85, 8'd71, 8'd163, 8'd35, 8'd221, 8'd81, 8'd175, 8'd58,
      8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38, 8'd44, 8'd83,
      8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9, 8'd211, 8'd223, 8'd205, 8'd244,
      8'd65, 8'd129, 8'd77, 8'd82, 8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193,
      8'd171, 8'd250, 8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
      8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109, 8'd233, 8'd203,
      8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57, 8'd242, 8'd239, 8'd183, 8'd14,
      8'd102, 8'd88, 8'd208, 8'd228, 8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117,
      8'd75, 8'd10, 8'd49, 8'd68, 8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26,
      8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17, 8'd131, 8'd20
   };

endpackage

// ----- rtl/core/md2_datapath.sv -----
`timescale 1ns / 1ps

module md2_datapath (
   input  logic             clock,
   input  logic             reset,
   input  md2_pkg::cmd_type cmd,
   input  logic [7:0]       data_byte,
   output logic [7:0]       head_byte
);
   import md2_pkg::*;

   logic [7:0] mix_ff  [MIX_BYTES];
   logic [7:0] mix_in  [MIX_BYTES];
   logic [7:0] csum_ff [BLOCK_BYTES];
   logic [7:0] csum_in [BLOCK_BYTES];
   logic [7:0] buf_ff  [BLOCK_BYTES];
   logic [7:0] buf_in  [BLOCK_BYTES];
   logic [7:0] acc_ff, acc_in;
   logic [7:0] cacc_ff, cacc_in;
   logic [7:0] mix_new, csum_new;

   assign mix_new   = mix_ff[0] ^ PI_ROM[acc_ff];
   assign csum_new  = csum_ff[0] ^ PI_ROM[buf_ff[0] ^ cacc_ff];
   assign head_byte = mix_ff[0];

   always_comb begin
      mix_in  = mix_ff;
      csum_in = csum_ff;
      buf_in  = buf_ff;
      acc_in  = acc_ff;
      cacc_in = cacc_ff;
      if (cmd.buf_shift) begin
         for (int i = 0; i < BLOCK_BYTES - 1; i++) buf_in[i] = buf_ff[i + 1];
         buf_in[BLOCK_BYTES - 1] = cmd.buf_use_pad ? cmd.pad_byte : data_byte;
      end
      if (cmd.copy_csum) buf_in = csum_ff;
      if (cmd.load_mix) begin
         for (int k = 0; k < BLOCK_BYTES; k++) begin
            mix_in[BLOCK_BYTES + k]     = buf_ff[k];
            mix_in[2 * BLOCK_BYTES + k] = mix_ff[k] ^ buf_ff[k];
         end
         acc_in  = '0;
         cacc_in = csum_ff[BLOCK_BYTES - 1];
      end
      // rotate the mix state so the working byte always sits at the head
      if (cmd.mix_step) begin
         for (int i = 0; i < MIX_BYTES - 1; i++) mix_in[i] = mix_ff[i + 1];
         mix_in[MIX_BYTES - 1] = mix_new;
         acc_in = cmd.round_end ? mix_new + {3'b000, cmd.round} : mix_new;
      end
      if (cmd.csum_step) begin
         for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
            csum_in[i] = csum_ff[i + 1];
            buf_in[i]  = buf_ff[i + 1];
         end
         csum_in[BLOCK_BYTES - 1] = csum_new;
         buf_in[BLOCK_BYTES - 1]  = buf_ff[0];
         cacc_in = csum_new;
      end
      if (cmd.emit_shift) begin
         for (int i = 0; i < MIX_BYTES - 1; i++) mix_in[i] = mix_ff[i + 1];
         mix_in[MIX_BYTES - 1] = '0;
      end
      if (cmd.clear) begin
         for (int i = 0; i < MIX_BYTES; i++) mix_in[i] = '0;
         for (int i = 0; i < BLOCK_BYTES; i++) csum_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MIX_BYTES; i++) mix_ff[i] <= '0;
         for (int i = 0; i < BLOCK_BYTES; i++) csum_ff[i] <= '0;
      end else begin
         mix_ff  <= mix_in;
         csum_ff <= csum_in;
      end
      buf_ff  <= buf_in;
      acc_ff  <= acc_in;
      cacc_ff <= cacc_in;
   end

endmodule

// ----- rtl/core/md2_ctrl.sv -----
`timescale 1ns / 1ps

module md2_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_byte_valid,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_last_out,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_digest_length,
   output md2_pkg::cmd_type cmd
);
   import md2_pkg::*;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] fill_ff, fill_in;
   logic       last_ff, last_in;
   logic [7:0] pad_ff, pad_in;
   logic [5:0] step_ff, step_in;
   logic [4:0] round_ff, round_in;
   logic [3:0] emit_ff, emit_in;
   logic [4:0] dlen_ff;
   logic [4:0] count;
   logic       final_byte;

   assign csr_ready  = 1'b1;
   assign count      = (dlen_ff > 5'd16) ? 5'd16 : dlen_ff;
   assign final_byte = ({1'b0, emit_ff} + 5'd1) == count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DATA;
         fill_ff  <= '0;
         last_ff  <= 1'b0;
         step_ff  <= '0;
         round_ff <= '0;
         emit_ff  <= '0;
         dlen_ff  <= 5'd16;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         last_ff  <= last_in;
         step_ff  <= step_in;
         round_ff <= round_in;
         emit_ff  <= emit_in;
         if (csr_valid) dlen_ff <= csr_digest_length;
      end
      pad_ff <= pad_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      pad_in       = pad_ff;
      step_in      = step_ff;
      round_in     = round_ff;
      emit_in      = emit_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_last_out = 1'b0;
      cmd          = '0;
      cmd.pad_byte = pad_ff;
      cmd.round    = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.buf_shift = req_byte_valid;
               fill_in = fill_ff + {3'b000, req_byte_valid};
               last_in = req_last;
               pad_in  = 8'd16 - {4'b0000, fill_in};
               if (req_byte_valid && fill_ff == 4'd15) begin
                  phase_in = PH_DATA;
                  state_in = ST_LOAD;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.buf_shift   = 1'b1;
            cmd.buf_use_pad = 1'b1;
            fill_in = fill_ff + 4'd1;
            if (fill_ff == 4'd15) begin
               phase_in = PH_PAD;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_mix = 1'b1;
            step_in  = '0;
            round_in = '0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix_step  = 1'b1;
            cmd.round_end = step_ff == 6'(MIX_BYTES - 1);
            step_in = step_ff + 6'd1;
            if (cmd.round_end) begin
               step_in  = '0;
               round_in = round_ff + 5'd1;
               if (round_ff == 5'(ROUNDS - 1)) begin
                  if (phase_ff == PH_SUM) begin
                     emit_in = '0;
                     if (count == 5'd0) begin
                        cmd.clear = 1'b1;
                        fill_in   = '0;
                        last_in   = 1'b0;
                        state_in  = ST_IDLE;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end else begin
                     state_in = ST_CSUM;
                  end
               end
            end
         end
         ST_CSUM: begin
            cmd.csum_step = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(BLOCK_BYTES - 1)) begin
               step_in = '0;
               if (phase_ff == PH_PAD) begin
                  state_in = ST_COPY;
               end else if (last_ff) begin
                  pad_in   = 8'd16;
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_COPY: begin
            cmd.copy_csum = 1'b1;
            phase_in = PH_SUM;
            state_in = ST_LOAD;
         end
         ST_EMIT: begin
            rsp_valid    = 1'b1;
            rsp_last_out = final_byte;
            if (rsp_ready) begin
               cmd.emit_shift = 1'b1;
               emit_in = emit_ff + 4'd1;
               if (final_byte) begin
                  cmd.clear = 1'b1;
                  fill_in   = '0;
                  last_in   = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/md2_hash_engine.sv -----
`timescale 1ns / 1ps

// MD2 message digest engine. Send one message item per req handshake; an item with
// req_byte_valid low carries no byte, and req_last ends the message. A byte that fills
// a 16-byte block starts one compression (one PI substitution a cycle over 18 rounds
// of 48 bytes, plus the 16-step checksum fold). The end of a message adds padding
// (one pad byte per cycle) and two further compressions before the first digest byte
// appears on rsp. The first digest_length bytes (at most 16) are then handed out one
// per rsp handshake, the final one flagged by rsp_last_out. No item is accepted while
// a block is being compressed or the digest is going out. csr_digest_length may be
// written at any idle time and takes effect once it is registered.
module md2_hash_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_valid,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_digest_byte,
   output logic       rsp_last_out,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_digest_length
);
   import md2_pkg::*;

   cmd_type cmd;

   md2_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_valid    (req_byte_valid),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_last_out      (rsp_last_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_digest_length (csr_digest_length),
      .cmd               (cmd)
   );

   md2_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_data_byte),
      .head_byte (rsp_digest_byte)
   );

endmodule

// ----- rtl/core/md2_checker.sv -----
`timescale 1ns / 1ps

module md2_hash_engine_props (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_digest_byte,
   input logic       rsp_last_out
);

   // no new item while the digest is going out
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("item accepted during digest output");

   // the final digest byte ends the output burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_out |=> !rsp_valid)
      else $error("digest output continues past final byte");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_byte))
      else $error("stalled digest byte changed");

endmodule

bind md2_hash_engine md2_hash_engine_props u_md2_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_byte (rsp_digest_byte),
   .rsp_last_out    (rsp_last_out)
);
